FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, command codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

FILE: sv/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Element ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [ADDR_W-1:0]               waddr,
  input  logic signed [deq_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]               raddr,
  output logic signed [deq_pkg::DATA_W-1:0] rdata
);

  logic signed [deq_pkg::DATA_W-1:0] ram_r [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
    rdata_r <= ram_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens on a clock edge with start high and
//   busy low. in_kind selects push front/rear, pop front/rear or dump;
//   in_value is the element to push.
//   Result channel: out_valid strobes for one cycle per result; the
//   receiver cannot stall, so every strobe must be taken as it comes.
//   Every result carries front, rear and count after the command.
// Result timing:
//   Push, error cases and unknown codes: result in the cycle after the
//   transfer, a new command every cycle.
//   Pop: result in the cycle after the transfer when the new end element is
//   already in a register (one or two elements held), else after ST_POP, which
//   takes the new end from one RAM read; busy is high in ST_POP.
//   Dump of n elements: n results back to back, the first after the RAM read
//   and result registers; one RAM read per element sets the pace.
// Reset: rst_n (synchronous) empties the deque. RAM contents are not
//   cleared; only held entries are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [deq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic [deq_pkg::STAT_W-1:0]        out_status,
  output logic signed [deq_pkg::DATA_W-1:0] out_item,
  output logic signed [deq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0] out_rear_value,
  output logic [deq_pkg::CNT_W-1:0]         out_count,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = deq_pkg::CNT_W;
  localparam int DW    = deq_pkg::DATA_W;
  localparam logic [CW:0]      DEPTH_S  = (CW+1)'(DEPTH);
  localparam logic [CW-1:0]    DEPTH_C  = CW'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_DUMP} state_t;

  // (idx + off) mod DEPTH; both operands stay below DEPTH+DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [CW-1:0]    off);
    logic [CW:0] s;
    s = (CW+1)'(idx) + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IDX_W-1:0];
  endfunction

  // Control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;    // next dump read address
  logic [CW-1:0]     dump_k_r, dump_k_nxt;    // dump results already sent
  logic              pop_front_r, pop_front_nxt;

  // Cached end elements, zero when empty
  logic signed [DW-1:0] front_r, front_nxt;
  logic signed [DW-1:0] rear_r, rear_nxt;

  // Result registers
  logic                         out_valid_r, out_valid_nxt;
  logic [deq_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic signed [DW-1:0]         out_item_r, out_item_nxt;
  logic                         out_last_r, out_last_nxt;

  // RAM port
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic signed [DW-1:0] mem_rdata;

  logic             is_full;
  logic             is_empty;
  logic [IDX_W-1:0] head_dec;
  logic             dump_last;

  deq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign dump_last = (dump_k_r == count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    dump_k_nxt     = dump_k_r;
    pop_front_nxt  = pop_front_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = in_value;
    mem_raddr      = rd_ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_last_nxt = 1'b1;
          unique case (in_kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = in_value;
              if (is_full) begin
                out_status_nxt = deq_pkg::STAT_FULL;
              end else begin
                out_status_nxt = deq_pkg::STAT_OK;
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                if (in_kind == deq_pkg::KIND_PUSH_FRONT) begin
                  mem_waddr = head_dec;
                  head_nxt  = head_dec;
                  front_nxt = in_value;
                  if (is_empty) begin
                    rear_nxt = in_value;
                  end
                end else begin
                  mem_waddr = wrap_add(head_r, count_r);
                  rear_nxt  = in_value;
                  if (is_empty) begin
                    front_nxt = in_value;
                  end
                end
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::STAT_EMPTY;
                out_item_nxt   = '0;
              end else begin
                out_status_nxt = deq_pkg::STAT_OK;
                count_nxt      = count_r - 1'b1;
                pop_front_nxt  = (in_kind == deq_pkg::KIND_POP_FRONT);
                out_item_nxt   = pop_front_nxt ? front_r : rear_r;
                if (pop_front_nxt) begin
                  head_nxt = wrap_add(head_r, CW'(1));
                end
                if (count_r == CW'(1)) begin
                  out_valid_nxt = 1'b1;
                  front_nxt     = '0;
                  rear_nxt      = '0;
                end else if (count_r == CW'(2)) begin
                  // remaining element is the other cached end
                  out_valid_nxt = 1'b1;
                  if (pop_front_nxt) begin
                    front_nxt = rear_r;
                  end else begin
                    rear_nxt = front_r;
                  end
                end else begin
                  // fetch the new end element from RAM
                  mem_raddr = pop_front_nxt ? wrap_add(head_r, CW'(1))
                                            : wrap_add(head_r, count_r - CW'(2));
                  state_nxt = ST_POP;
                end
              end
            end
            deq_pkg::KIND_DUMP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::STAT_EMPTY;
                out_item_nxt   = '0;
              end else begin
                mem_raddr  = head_r;
                rd_ptr_nxt = wrap_add(head_r, CW'(1));
                dump_k_nxt = '0;
                state_nxt  = ST_DUMP;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = deq_pkg::STAT_OK;
              out_item_nxt   = '0;
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt = 1'b1;
        if (pop_front_r) begin
          front_nxt = mem_rdata;
        end else begin
          rear_nxt = mem_rdata;
        end
        state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        // one element per cycle; next read overlaps this result
        out_valid_nxt  = 1'b1;
        out_status_nxt = deq_pkg::STAT_OK;
        out_item_nxt   = mem_rdata;
        out_last_nxt   = dump_last;
        mem_raddr      = rd_ptr_r;
        rd_ptr_nxt     = wrap_add(rd_ptr_r, CW'(1));
        dump_k_nxt     = dump_k_r + 1'b1;
        if (dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      front_r     <= '0;
      rear_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ptr_r     <= rd_ptr_nxt;
    dump_k_r     <= dump_k_nxt;
    pop_front_r  <= pop_front_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  // front and rear registers only move on result edges; count moves on the transfer
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item        = out_item_r;
  assign out_last        = out_last_r;
  assign out_front_value = front_r;
  assign out_rear_value  = rear_r;
  assign out_count       = count_r;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count above depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |-> (out_front_value == '0 && out_rear_value == '0))
    else $error("empty deque reports nonzero end values");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == deq_pkg::STAT_FULL) |-> (out_count == DEPTH_C))
    else $error("full status while not full");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (out_valid && out_last))
    else $error("pop RAM fetch did not produce a result");

endmodule

FILE: tb/sv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the bounded double-ended queue. A shadow deque in
// the bench predicts every result of each accepted command. A checker
// compares each strobed result, field by field, with the oldest prediction.
// Stimulus is a short directed part followed by random command traffic.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

  localparam int RING_DEPTH   = 64;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int REPORT_LIMIT = 10;
  // Cycles with neither a command transfer nor a result before giving up.
  // The slowest legal gap is a pop that reads RAM or a short sender gap.
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Codes the block does not define; it must answer them with a plain status
  localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [deq_pkg::STAT_W-1:0]        status;
    logic signed [deq_pkg::DATA_W-1:0] item;
    logic signed [deq_pkg::DATA_W-1:0] front_value;
    logic signed [deq_pkg::DATA_W-1:0] rear_value;
    logic [deq_pkg::CNT_W-1:0]         count;
    logic                              last;
  } deq_reply_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // --------------------------------------------------------------------------
  logic                              clk      = 1'b0;
  logic                              rst_n    = 1'b0;
  logic                              start    = 1'b0;
  logic [deq_pkg::KIND_W-1:0]        in_kind  = '0;
  logic signed [deq_pkg::DATA_W-1:0] in_value = '0;

  logic                              busy;
  logic                              out_valid;
  logic [deq_pkg::STAT_W-1:0]        out_status;
  logic signed [deq_pkg::DATA_W-1:0] out_item;
  logic signed [deq_pkg::DATA_W-1:0] out_front_value;
  logic signed [deq_pkg::DATA_W-1:0] out_rear_value;
  logic [deq_pkg::CNT_W-1:0]         out_count;
  logic                              out_last;

  always #10 clk = ~clk;

  double_ended_queue #(
    .DEPTH(RING_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_item        (out_item),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_count       (out_count),
    .out_last        (out_last)
  );

  // --------------------------------------------------------------------------
  // Shadow deque: same ring layout as the block, head index plus count
  // --------------------------------------------------------------------------
  logic signed [deq_pkg::DATA_W-1:0] shadow_ring [RING_DEPTH];
  logic [IDX_W-1:0]                  shadow_head  = '0;
  logic [deq_pkg::CNT_W-1:0]         shadow_count = '0;

  deq_reply_t awaited_replies [$];

  // Bookkeeping for the summary
  int commands_sent   = 0;
  int replies_checked = 0;
  int kind_hits [8]   = '{default: 0};
  int full_refusals   = 0;
  int empty_refusals  = 0;
  int peak_count      = 0;
  int fault_count     = 0;

  bit gaps_on = 1'b1;

  // Queue one predicted result; front/rear/count reflect the shadow state now
  function automatic void queue_reply(input logic [deq_pkg::STAT_W-1:0] status,
                                      input logic signed [deq_pkg::DATA_W-1:0] item,
                                      input logic last);
    deq_reply_t       r;
    logic [IDX_W-1:0] tail;
    tail          = IDX_W'(shadow_head + shadow_count - 1);
    r.status      = status;
    r.item        = item;
    r.front_value = (shadow_count != 0) ? shadow_ring[shadow_head] : '0;
    r.rear_value  = (shadow_count != 0) ? shadow_ring[tail] : '0;
    r.count       = shadow_count;
    r.last        = last;
    awaited_replies.push_back(r);
  endfunction

  // Apply one accepted command to the shadow deque and predict its results
  function automatic void shadow_execute(input logic [deq_pkg::KIND_W-1:0] kind,
                                         input logic signed [deq_pkg::DATA_W-1:0] value);
    logic [IDX_W-1:0]                  slot;
    logic signed [deq_pkg::DATA_W-1:0] taken;
    int                                k;
    case (kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
        if (shadow_count >= RING_DEPTH) begin
          // full: value echoed, nothing moves
          full_refusals++;
          queue_reply(deq_pkg::STAT_FULL, value, 1'b1);
        end else begin
          if (kind == deq_pkg::KIND_PUSH_FRONT) begin
            shadow_head = IDX_W'(shadow_head - 1);
            shadow_ring[shadow_head] = value;
          end else begin
            slot = IDX_W'(shadow_head + shadow_count);
            shadow_ring[slot] = value;
          end
          shadow_count++;
          if (int'(shadow_count) > peak_count) peak_count = int'(shadow_count);
          queue_reply(deq_pkg::STAT_OK, value, 1'b1);
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
        if (shadow_count == 0) begin
          empty_refusals++;
          queue_reply(deq_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          if (kind == deq_pkg::KIND_POP_FRONT) begin
            taken = shadow_ring[shadow_head];
            shadow_head = IDX_W'(shadow_head + 1);
          end else begin
            slot  = IDX_W'(shadow_head + shadow_count - 1);
            taken = shadow_ring[slot];
          end
          shadow_count--;
          queue_reply(deq_pkg::STAT_OK, taken, 1'b1);
        end
      end
      deq_pkg::KIND_DUMP: begin
        if (shadow_count == 0) begin
          empty_refusals++;
          queue_reply(deq_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          // front to rear, last only on the rear element
          for (k = 0; k < shadow_count; k++) begin
            slot = IDX_W'(shadow_head + k);
            queue_reply(deq_pkg::STAT_OK, shadow_ring[slot], k == shadow_count - 1);
          end
        end
      end
      default: begin
        queue_reply(deq_pkg::STAT_OK, '0, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command sender: optional random gap, then hold start until the transfer
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [deq_pkg::KIND_W-1:0] kind,
                              input logic signed [deq_pkg::DATA_W-1:0] value);
    int gap;
    gap = 0;
    while (gaps_on && $urandom_range(0, 99) < 11) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    // start is high at every edge from here on; busy low marks the transfer
    do @(posedge clk); while (busy !== 1'b0);
    shadow_execute(kind, value);
    commands_sent++;
    kind_hits[kind]++;
  endtask

  // Values lean toward the corners of the signed range
  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Percentages for spare codes, dumps and pushes; the rest are pops
  function automatic logic [deq_pkg::KIND_W-1:0] pick_kind(input int push_pct,
                                                           input int dump_pct,
                                                           input int spare_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < spare_pct) begin
      case ($urandom_range(0, 2))
        0:       return KIND_SPARE_FIRST;
        1:       return KIND_SPARE_MID;
        default: return KIND_SPARE_LAST;
      endcase
    end
    if (roll < spare_pct + dump_pct) return deq_pkg::KIND_DUMP;
    if (roll < spare_pct + dump_pct + push_pct)
      return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_REAR;
    return $urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_REAR;
  endfunction

  task automatic send_random(input int push_pct, input int dump_pct,
                             input int spare_pct);
    logic [deq_pkg::KIND_W-1:0] kind;
    kind = pick_kind(push_pct, dump_pct, spare_pct);
    // pops, dumps and undefined codes ignore the value, so it stays fully random there
    if (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_REAR)
      send_command(kind, pick_value());
    else
      send_command(kind, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Pops and dump on an empty deque, and every undefined code
  task automatic test_empty_deque();
    send_command(deq_pkg::KIND_POP_FRONT, $urandom);
    send_command(deq_pkg::KIND_POP_REAR, $urandom);
    send_command(deq_pkg::KIND_DUMP, $urandom);
    send_command(KIND_SPARE_FIRST, $urandom);
    send_command(KIND_SPARE_MID, $urandom);
    send_command(KIND_SPARE_LAST, $urandom);
  endtask

  // Signed extremes at both ends, dump, and pops from four elements down
  task automatic test_extreme_values();
    send_command(deq_pkg::KIND_PUSH_FRONT, VAL_MIN);
    send_command(deq_pkg::KIND_PUSH_REAR, VAL_MAX);
    send_command(deq_pkg::KIND_PUSH_FRONT, -1);
    send_command(deq_pkg::KIND_PUSH_REAR, '0);
    send_command(KIND_SPARE_MID, $urandom);            // reports a non-empty deque
    send_command(deq_pkg::KIND_DUMP, '0);
    send_command(deq_pkg::KIND_POP_FRONT, '0);
    send_command(deq_pkg::KIND_POP_REAR, '0);
    send_command(deq_pkg::KIND_POP_REAR, '0);
    send_command(deq_pkg::KIND_POP_FRONT, '0);         // last element out at the front
    send_command(deq_pkg::KIND_POP_FRONT, '0);         // empty again
    // single element taken from the opposite end it went in
    send_command(deq_pkg::KIND_PUSH_REAR, 1);
    send_command(deq_pkg::KIND_DUMP, '0);              // one-element dump
    send_command(deq_pkg::KIND_POP_FRONT, '0);
    send_command(deq_pkg::KIND_PUSH_FRONT, 2);
    send_command(deq_pkg::KIND_POP_REAR, '0);
  endtask

  // No sender gaps here: fill to capacity, hit the full case at both ends,
  // dump all entries, then pop back down
  task automatic test_fill_to_full();
    gaps_on = 1'b0;
    while (shadow_count < RING_DEPTH)
      send_command($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT
                                        : deq_pkg::KIND_PUSH_REAR,
                   pick_value());
    send_command(deq_pkg::KIND_PUSH_FRONT, VAL_MIN);
    send_command(deq_pkg::KIND_PUSH_REAR, VAL_MAX);
    send_command(deq_pkg::KIND_PUSH_FRONT, $urandom);
    send_command(deq_pkg::KIND_PUSH_REAR, $urandom);
    send_command(deq_pkg::KIND_DUMP, $urandom);
    send_command(KIND_SPARE_LAST, $urandom);
    repeat (30)
      send_command($urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT
                                        : deq_pkg::KIND_POP_REAR,
                   $urandom);
    gaps_on = 1'b1;
  endtask

  // Balanced mix with sender gaps
  task automatic test_random_traffic();
    repeat (160) send_random(50, 8, 4);
  endtask

  // Pop-heavy run toward empty, then push-heavy back up
  task automatic test_drain_and_refill();
    repeat (35) send_random(20, 6, 4);
    repeat (35) send_random(75, 5, 2);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobe is taken; compare against oldest prediction
  // --------------------------------------------------------------------------
  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_replies
    deq_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        report_fault($sformatf("%0t: unexpected result status=%0d item=%0d",
                               $realtime, out_status, out_item));
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (out_status !== want.status || out_item !== want.item ||
            out_front_value !== want.front_value ||
            out_rear_value !== want.rear_value ||
            out_count !== want.count || out_last !== want.last) begin
          report_fault($sformatf({"%0t: mismatch exp st=%0d it=%0d fr=%0d rr=%0d",
                                  " n=%0d l=%0d | act st=%0d it=%0d fr=%0d rr=%0d",
                                  " n=%0d l=%0d"},
            $realtime, want.status, want.item, want.front_value,
            want.rear_value, want.count, want.last, out_status, out_item,
            out_front_value, out_rear_value, out_count, out_last));
        end
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      report_fault($sformatf("%0t: out_valid unknown", $realtime));
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transfer or result ends the run
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_deque();
    test_extreme_values();
    test_fill_to_full();
    test_random_traffic();
    test_drain_and_refill();

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display({"Ran %0d commands (push front/rear %0d/%0d, pop front/rear %0d/%0d,",
              " dump %0d, undefined codes %0d) and checked %0d results."},
             commands_sent, kind_hits[deq_pkg::KIND_PUSH_FRONT],
             kind_hits[deq_pkg::KIND_PUSH_REAR],
             kind_hits[deq_pkg::KIND_POP_FRONT], kind_hits[deq_pkg::KIND_POP_REAR],
             kind_hits[deq_pkg::KIND_DUMP],
             kind_hits[KIND_SPARE_FIRST] + kind_hits[KIND_SPARE_MID] +
             kind_hits[KIND_SPARE_LAST], replies_checked);
    $display("Peak fill %0d of %0d; %0d full refusals, %0d empty refusals, %0d faults.",
             peak_count, RING_DEPTH, full_refusals, empty_refusals, fault_count);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
